FILE: rtl/btte_pkg.sv
package btte_pkg;

  localparam int unsigned SecondsPerDay  = 86400;
  localparam int unsigned EpochDayOffset = 25567;
  localparam int unsigned DaysPerYear    = 365;
  localparam int unsigned SecondsPerMin  = 60;
  // floor(y / 100) == (y * Recip100) >> Recip100Shift for y < 1024
  localparam int unsigned Recip100       = 1311;
  localparam int unsigned Recip100Shift  = 17;
  localparam logic [3:0]  MonthDec       = 4'd11;
  localparam logic [3:0]  MonthMar       = 4'd2;

  typedef struct packed {
    logic [9:0] year_since_1900;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } req_t;

  typedef struct packed {
    logic [63:0] epoch_seconds;
    logic [8:0]  day_of_year;
    logic [2:0]  weekday;
  } res_t;

  // after year split
  typedef struct packed {
    logic [9:0]  year;
    logic [3:0]  mon;
    logic [4:0]  mday;
    logic [5:0]  sec;
    logic [10:0] hm;
    logic        year_zero;
    logic [7:0]  q4;      // (year-1) / 4
    logic [3:0]  q100;    // (year-1) / 100
    logic [1:0]  q400;    // (year-1+300) / 400
    logic [3:0]  qy100;   // year / 100
  } split_t;

  // after leap and day-of-year
  typedef struct packed {
    logic [9:0]  year;
    logic [7:0]  lm;      // leap years through year-1
    logic [9:0]  yday;    // two's complement, may be -1
    logic [11:0] wsum;
    logic [16:0] sod;
  } count_t;

  // after day count
  typedef struct packed {
    logic [19:0] days;    // two's complement
    logic [8:0]  yday;
    logic [4:0]  wfold;
    logic [16:0] sod;
  } days_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] month_wday_offset(input logic [3:0] m);
    logic [2:0] d;
    case (m)
      4'd0:    d = 3'd1;
      4'd1:    d = 3'd4;
      4'd2:    d = 3'd3;
      4'd3:    d = 3'd6;
      4'd4:    d = 3'd1;
      4'd5:    d = 3'd4;
      4'd6:    d = 3'd6;
      4'd7:    d = 3'd2;
      4'd8:    d = 3'd5;
      4'd9:    d = 3'd0;
      4'd10:   d = 3'd3;
      default: d = 3'd5;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/btte_split.sv
module btte_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  btte_pkg::req_t       req,
  output logic                 out_vld,
  output btte_pkg::split_t     out
);
  import btte_pkg::*;

  logic [9:0]  ym1;
  logic [20:0] p_ym1;
  logic [20:0] p_year;
  logic [10:0] z400;
  logic [1:0]  q400;
  split_t      s_next;

  always_comb begin
    ym1    = req.year_since_1900 - 10'd1;
    p_ym1  = {11'd0, ym1} * 21'(Recip100);
    p_year = {11'd0, req.year_since_1900} * 21'(Recip100);
    z400   = {1'b0, ym1} + 11'd300;
    if (z400 >= 11'd1200) begin
      q400 = 2'd3;
    end else if (z400 >= 11'd800) begin
      q400 = 2'd2;
    end else if (z400 >= 11'd400) begin
      q400 = 2'd1;
    end else begin
      q400 = 2'd0;
    end

    s_next.year      = req.year_since_1900;
    s_next.mon       = (req.month > MonthDec) ? MonthDec : req.month;
    s_next.mday      = req.day_of_month;
    s_next.sec       = req.second;
    s_next.hm        = 11'(req.hour) * 11'(SecondsPerMin) + 11'(req.minute);
    s_next.year_zero = (req.year_since_1900 == 10'd0);
    s_next.q4        = ym1[9:2];
    s_next.q100      = p_ym1[Recip100Shift +: 4];
    s_next.q400      = q400;
    s_next.qy100     = p_year[Recip100Shift +: 4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out <= s_next;
  end

endmodule

FILE: rtl/btte_count.sv
module btte_count (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  btte_pkg::split_t     in,
  output logic                 out_vld,
  output btte_pkg::days_t      out
);
  import btte_pkg::*;

  // stage B: leap flag, leap count, day of year, weekday sum, seconds of day
  logic        leap;
  logic        early;
  logic [8:0]  lm9;
  logic [7:0]  lp;
  logic [9:0]  hund;
  count_t      b_next;
  logic        b_vld;
  count_t      b;
  // stage C: day count, first mod-7 fold
  days_t       c_next;

  always_comb begin
    hund  = 10'(in.qy100) * 10'd100;
    // year%400 == 100 covers 2000, 2400, 2800 in this range
    leap  = ((in.year[1:0] == 2'd0) && (in.year != hund)) ||
            (in.year == 10'd100) || (in.year == 10'd500) || (in.year == 10'd900);
    early = (in.mon < MonthMar);
    lm9   = in.year_zero ? 9'd0 :
            ({1'b0, in.q4} - {5'd0, in.q100} + {7'd0, in.q400});
    lp    = lm9[7:0] + {7'd0, leap & ~early};

    b_next.year = in.year;
    b_next.lm   = lm9[7:0];
    b_next.yday = {5'd0, in.mday} + {1'b0, days_before_month(in.mon)}
                + {9'd0, leap & ~early} - 10'd1;
    // pseudo year is year-1 for Jan/Feb; total stays non-negative
    b_next.wsum = {2'd0, in.year} + {4'd0, lp} + {9'd0, month_wday_offset(in.mon)}
                + {7'd0, in.mday} - {11'd0, early};
    b_next.sod  = {6'd0, in.hm} * 17'(SecondsPerMin) + {11'd0, in.sec};
  end

  always_comb begin
    c_next.days  = {{10{b.yday[9]}}, b.yday} + {10'd0, b.year} * 20'(DaysPerYear)
                 + {12'd0, b.lm} - 20'(EpochDayOffset);
    c_next.yday  = b.yday[8:0];
    // 8 == 1 mod 7: sum the octal digits
    c_next.wfold = {2'd0, b.wsum[2:0]} + {2'd0, b.wsum[5:3]}
                 + {2'd0, b.wsum[8:6]} + {2'd0, b.wsum[11:9]};
    c_next.sod   = b.sod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      b_vld   <= in_vld;
      out_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    b   <= b_next;
    out <= c_next;
  end

endmodule

FILE: rtl/btte_scale.sv
module btte_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  btte_pkg::days_t      in,
  output logic                 out_vld,
  output btte_pkg::res_t       out
);
  import btte_pkg::*;

  logic signed [37:0] prod_full;
  logic [3:0]         f2;
  logic [2:0]         wday_next;
  logic               d_vld;
  logic [36:0]        d_prod;
  logic [2:0]         d_wday;
  logic [8:0]         d_yday;
  logic [16:0]        d_sod;
  res_t               res_next;

  always_comb begin
    prod_full = $signed(in.days) * 38'sd86400;
    f2        = {1'b0, in.wfold[2:0]} + {2'd0, in.wfold[4:3]};
    wday_next = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
  end

  always_comb begin
    res_next.epoch_seconds = {{27{d_prod[36]}}, d_prod} + {47'd0, d_sod};
    res_next.day_of_year   = d_yday;
    res_next.weekday       = d_wday;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      d_vld   <= in_vld;
      out_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_prod <= prod_full[36:0];
    d_wday <= wday_next;
    d_yday <= in.yday;
    d_sod  <= in.sod;
    out    <= res_next;
  end

endmodule

FILE: rtl/broken_down_time_to_epoch_seconds_core.sv
// Throughput: one request per cycle; busy is always low, five register stages
//   (year split, leap/day-of-year, day count, x86400 multiply, 64-bit add).
// The receiver cannot stall: each result shows on res for one cycle with done.
// Reset (rst, synchronous) clears only the stage valid bits; no state is kept.
module broken_down_time_to_epoch_seconds_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  btte_pkg::req_t   req,
  output logic             done,
  output btte_pkg::res_t   res
);
  import btte_pkg::*;

  logic   a_vld;
  split_t a;
  logic   c_vld;
  days_t  c;

  assign busy = 1'b0;

  btte_split u_split (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start & ~busy),
    .req     (req),
    .out_vld (a_vld),
    .out     (a)
  );

  btte_count u_count (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (a_vld),
    .in      (a),
    .out_vld (c_vld),
    .out     (c)
  );

  btte_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (c_vld),
    .in      (c),
    .out_vld (done),
    .out     (res)
  );

endmodule

FILE: verif/broken_down_time_to_epoch_seconds_checker.sv
module broken_down_time_to_epoch_seconds_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  btte_pkg::req_t   req,
  input  logic             done,
  input  btte_pkg::res_t   res,
  output int               errors,
  output int               outstanding
);
  import btte_pkg::*;

  int days_before_month_tbl[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  int weekday_offset_tbl[12]    = '{1, 4, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

  res_t expected_times[$];
  int   mismatches = 0;

  assign errors = mismatches;

  // odd rule: y counts from 1900, so y % 400 == 100 is a multiple of 400 AD
  function automatic bit year_has_feb29(longint y);
    bit leap;
    leap = (y % 4) == 0;
    if ((y % 100) == 0) leap = 1'b0;
    if ((y % 400) == 100) leap = 1'b1;
    return leap;
  endfunction

  // leap years from 1901 through 1900+y; zero for y = -1
  function automatic longint leap_count(longint y);
    return (y / 4) - (y / 100) + ((y + 300) / 400);
  endfunction

  function automatic res_t calendar_to_epoch(req_t r);
    longint yr, mday, hr, mn, sc, yday, pseudo, wsum, days, sod, secs;
    int     m;
    res_t   x;
    yr   = longint'(r.year_since_1900);
    mday = longint'(r.day_of_month);
    hr   = longint'(r.hour);
    mn   = longint'(r.minute);
    sc   = longint'(r.second);
    m    = int'(r.month);
    if (m > int'(MonthDec)) m = int'(MonthDec);
    yday = mday - 1 + days_before_month_tbl[m];
    if (m >= int'(MonthMar) && year_has_feb29(yr)) yday = yday + 1;
    pseudo = (m < int'(MonthMar)) ? yr - 1 : yr;
    wsum = (pseudo + leap_count(pseudo) + weekday_offset_tbl[m] + mday) % 7;
    if (wsum < 0) wsum = wsum + 7;
    days = yday + longint'(DaysPerYear) * yr - longint'(EpochDayOffset) + leap_count(yr - 1);
    sod  = (hr * 60 + mn) * 60 + sc;
    secs = days * longint'(SecondsPerDay) + sod;  // wraps mod 2^64 below 1970
    x.epoch_seconds = secs;
    x.day_of_year   = yday[8:0];
    x.weekday       = wsum[2:0];
    return x;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (done) begin
        if (expected_times.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: epoch=%0h yday=%0d wday=%0d",
                     res.epoch_seconds, res.day_of_year, res.weekday);
        end else begin
          want = expected_times.pop_front();
          if (res.epoch_seconds !== want.epoch_seconds ||
              res.day_of_year !== want.day_of_year ||
              res.weekday !== want.weekday) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp epoch=%0h yday=%0d wday=%0d, got epoch=%0h yday=%0d wday=%0d",
                       want.epoch_seconds, want.day_of_year, want.weekday,
                       res.epoch_seconds, res.day_of_year, res.weekday);
          end
        end
      end
      if (start && !busy)
        expected_times.push_back(calendar_to_epoch(req));
      outstanding <= expected_times.size();
    end
  end

endmodule

FILE: verif/broken_down_time_to_epoch_seconds_core_test.sv
module broken_down_time_to_epoch_seconds_core_test;
  import btte_pkg::*;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  res_t res;
  int   errors;
  int   outstanding;

  broken_down_time_to_epoch_seconds_core dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .res   (res)
  );

  broken_down_time_to_epoch_seconds_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .res         (res),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** broken_down_time_to_epoch_seconds_core: FAILED **");
    $finish;
  end

  // holds start high until the request is taken, then drops it for the gap if gap is nonzero
  task automatic send_request(req_t r, int gap);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_time(int y, int m, int d, int h, int mi, int s);
    req_t r;
    r.year_since_1900 = 10'(y);
    r.month           = 4'(m);
    r.day_of_month    = 5'(d);
    r.hour            = 5'(h);
    r.minute          = 6'(mi);
    r.second          = 6'(s);
    send_request(r, $urandom_range(0, 4));
  endtask

  initial begin
    req_t r;
    bit   no_gaps;
    int   i;
    int   n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_time(70, 0, 1, 0, 0, 0);        // epoch zero
    send_time(69, 11, 31, 23, 59, 59);   // one second before the epoch
    send_time(0, 0, 1, 0, 0, 0);
    send_time(0, 0, 0, 0, 0, 0);         // day zero in January of year 0
    send_time(0, 1, 28, 12, 30, 30);
    send_time(0, 2, 1, 0, 0, 0);         // 1900 is not a leap year
    send_time(100, 1, 29, 12, 0, 0);     // 2000 is
    send_time(100, 2, 1, 0, 0, 0);
    send_time(100, 11, 31, 23, 59, 60);  // leap second
    send_time(200, 2, 1, 0, 0, 0);       // 2100 is not
    send_time(500, 2, 1, 0, 0, 0);       // 2400 is
    send_time(300, 2, 1, 6, 7, 8);
    send_time(96, 5, 15, 10, 20, 30);
    send_time(1, 0, 1, 0, 0, 0);
    send_time(4, 2, 1, 0, 0, 0);
    send_time(138, 0, 19, 3, 14, 7);
    send_time(124, 12, 5, 1, 2, 3);      // months past December clamp
    send_time(124, 13, 0, 0, 0, 0);
    send_time(70, 14, 1, 0, 0, 0);
    send_time(70, 6, 0, 31, 63, 63);     // clock fields past their range
    send_time(1023, 11, 31, 23, 59, 60);
    send_time(1023, 15, 31, 31, 63, 63);
    send_time(1023, 0, 0, 0, 0, 0);

    no_gaps = 1'b0;
    for (n = 0; n < 1200; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r.year_since_1900 = 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 3) != 0) begin
        r.month        = 4'($urandom_range(0, 11));
        r.day_of_month = 5'($urandom_range(1, 31));
        r.hour         = 5'($urandom_range(0, 23));
        r.minute       = 6'($urandom_range(0, 59));
        r.second       = 6'($urandom_range(0, 60));
      end else begin
        r.month        = 4'($urandom_range(0, 15));
        r.day_of_month = 5'($urandom_range(0, 31));
        r.hour         = 5'($urandom_range(0, 31));
        r.minute       = 6'($urandom_range(0, 63));
        r.second       = 6'($urandom_range(0, 63));
      end
      send_request(r, no_gaps ? 0 : $urandom_range(0, 4));
    end
    start <= 1'b0;

    for (i = 0; i < 1000 && outstanding != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0 && outstanding == 0)
      $display("** broken_down_time_to_epoch_seconds_core: PASSED **");
    else
      $display("** broken_down_time_to_epoch_seconds_core: FAILED **");
    $finish;
  end

endmodule
